/* src/avr_pkg.sv */
package avr_pkg;

    localparam int MAX_DIMS    = 8;
    localparam int MAX_PAIRS   = 4;
    localparam int COORD_WIDTH = 32;
    localparam int CS_BITS     = 29;
    localparam int NOUT        = MAX_DIMS - 1;

    localparam int MAG_W  = 30;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int N_W    = SQ_W + 1;
    localparam int RES_W  = N_W + 1;
    localparam int R_W    = 31;
    localparam int DV_W   = R_W + 1;
    localparam int Q_W    = 30;
    localparam int PROD_W = 63;

    localparam int ST_PREP    = 0;
    localparam int ST_SQ      = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_SQRT0   = 3;
    localparam int SQRT_STEPS = 31;
    localparam int ST_DIVI    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV0    = ST_DIVI + 1;
    localparam int DIV_STEPS  = Q_W;
    localparam int ST_MUL     = ST_DIV0 + DIV_STEPS;
    localparam int ST_RND     = ST_MUL + 1;
    localparam int ST_PLACE   = ST_RND + 1;
    localparam int N_STAGES   = ST_PLACE + 2;

    localparam logic [1:0] REG_DIMS   = 2'd0;
    localparam logic [1:0] REG_PAIRS  = 2'd1;
    localparam logic [1:0] REG_XSLOTS = 2'd2;
    localparam logic [1:0] REG_YSLOTS = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic                                    flag;
        logic                                    sa;
        logic                                    sb;
        logic [MAG_W-1:0]                        ma;
        logic [MAG_W-1:0]                        mb;
        logic [SQ_W-1:0]                         na;
        logic [SQ_W-1:0]                         nb;
        logic [N_W-1:0]                          rem;
        logic [RES_W-1:0]                        res;
        logic [N_W-1:0]                          dc;
        logic [N_W-1:0]                          ds;
        logic [DV_W-1:0]                         dv;
        logic [Q_W-1:0]                          qc;
        logic [Q_W-1:0]                          qs;
        logic [MAX_PAIRS-1:0][3:0][PROD_W-1:0]   prod;
        logic [MAX_PAIRS-1:0][1:0][COORD_WIDTH-1:0] rot;
        logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]    v;
        logic [NOUT-1:0][COORD_WIDTH-1:0]        o;
    } stage_t;

endpackage

/* src/avr_if.sv */
interface avr_cfg_if;
    import avr_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface avr_in_if;
    import avr_pkg::*;
    logic   valid;
    logic   ready;
    coord_t coord0;
    coord_t coord1;
    coord_t coord2;
    coord_t coord3;
    coord_t coord4;
    coord_t coord5;
    coord_t coord6;
    coord_t coord7;
    modport source (output valid, output coord0, output coord1, output coord2, output coord3,
                    output coord4, output coord5, output coord6, output coord7, input ready);
    modport sink (input valid, input coord0, input coord1, input coord2, input coord3,
                  input coord4, input coord5, input coord6, input coord7, output ready);
endinterface

interface avr_out_if;
    import avr_pkg::*;
    logic   valid;
    logic   ready;
    coord_t out0;
    coord_t out1;
    coord_t out2;
    coord_t out3;
    coord_t out4;
    coord_t out5;
    coord_t out6;
    logic   ref_zero;
    modport source (output valid, output out0, output out1, output out2, output out3,
                    output out4, output out5, output out6, output ref_zero, input ready);
    modport sink (input valid, input out0, input out1, input out2, input out3,
                  input out4, input out5, input out6, input ref_zero, output ready);
endinterface

/* src/azimuthal_vector_rotation.sv */
// channel  role   word
// cfg      sink   register index, 12-bit write data
// evt      sink   eight signed Q16.16 coordinates
// rot      source seven rotated coordinates and ref_zero flag
//
// one word accepted per cycle while the output is not stalled
// the pipeline holds the bit-per-stage square root (31) and divider (30) stages
// rst_n clears valid bits and sets the config registers to their reset values
// a stalled output freezes the whole pipeline, evt.ready is high while rot.ready is high or the last stage is empty
module azimuthal_vector_rotation (
    input  logic     clk,
    input  logic     rst_n,
    avr_cfg_if.sink  cfg,
    avr_in_if.sink   evt,
    avr_out_if.source rot
);
    import avr_pkg::*;

    logic [3:0]  dims_reg;
    logic [2:0]  pcnt_reg;
    logic [11:0] xs_reg;
    logic [11:0] ys_reg;

    logic [3:0] d;
    logic [3:0] nout;
    logic [2:0] np;
    logic [2:0] xr;
    logic [2:0] yr;

    stage_t pipe_reg  [N_STAGES];
    stage_t pipe_next [N_STAGES];
    logic [N_STAGES-1:0] vld_reg;
    logic adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= 4'd8;
            pcnt_reg <= 3'd0;
            xs_reg   <= 12'd0;
            ys_reg   <= 12'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DIMS:   dims_reg <= cfg.data[3:0];
                REG_PAIRS:  pcnt_reg <= cfg.data[2:0];
                REG_XSLOTS: xs_reg   <= cfg.data;
                REG_YSLOTS: ys_reg   <= cfg.data;
                default:    dims_reg <= dims_reg;
            endcase
        end
    end

    assign d    = (dims_reg > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dims_reg;
    assign nout = (d == 4'd0) ? 4'd0 : d - 4'd1;
    assign np   = (pcnt_reg > 3'(MAX_PAIRS)) ? 3'(MAX_PAIRS) : pcnt_reg;
    assign xr   = xs_reg[2:0];
    assign yr   = ys_reg[2:0];

    // {ok, output slot} for input slot i
    function automatic logic [3:0] place_fn(input logic [2:0] i);
        logic [3:0] j;
        begin
            j = (i > xr) ? 4'(i) - 4'd1 : 4'(i);
            if (i == xr || j >= nout)
                place_fn = 4'd0;
            else
                place_fn = {1'b1, j[2:0]};
        end
    endfunction

    function automatic stage_t stage_fn(input int s, input stage_t p);
        stage_t q;
        coord_t x0;
        coord_t y0;
        coord_t cx;
        coord_t cy;
        logic [COORD_WIDTH-1:0] mx;
        logic [COORD_WIDTH-1:0] my;
        logic [1:0] k;
        logic [RES_W-1:0] bitv;
        logic [RES_W-1:0] trial;
        logic [RES_W-1:0] sh;
        logic [R_W-1:0] r;
        logic signed [Q_W:0] cs;
        logic signed [Q_W:0] sn;
        logic signed [63:0] t;
        logic signed [63:0] tr;
        logic [2:0] xi;
        logic [2:0] yi;
        logic [3:0] pl;
        int t_i;
        begin
            q = p;
            if (s == ST_PREP)
            begin
                for (int i = 0; i < MAX_DIMS; i++)
                    q.v[i] = (4'(i) < d) ? p.v[i] : '0;
                x0 = q.v[xr];
                y0 = q.v[yr];
                mx = x0[COORD_WIDTH-1] ? (~x0 + 1'b1) : x0;
                my = y0[COORD_WIDTH-1] ? (~y0 + 1'b1) : y0;
                if (mx[31] || my[31])
                    k = 2'd2;
                else if (mx[30] || my[30])
                    k = 2'd1;
                else
                    k = 2'd0;
                q.ma   = MAG_W'(mx >> k);
                q.mb   = MAG_W'(my >> k);
                q.sa   = x0[COORD_WIDTH-1];
                q.sb   = y0[COORD_WIDTH-1];
                q.flag = (np != 3'd0) && (x0 == '0) && (y0 == '0);
            end
            else if (s == ST_SQ)
            begin
                q.na = SQ_W'(p.ma) * SQ_W'(p.ma);
                q.nb = SQ_W'(p.mb) * SQ_W'(p.mb);
            end
            else if (s == ST_SUM)
            begin
                q.rem = N_W'(p.na) + N_W'(p.nb);
                q.res = '0;
            end
            else if (s >= ST_SQRT0 && s < ST_DIVI)
            begin
                t_i   = s - ST_SQRT0;
                bitv  = RES_W'(1) << (60 - 2 * t_i);
                trial = p.res + bitv;
                if (RES_W'(p.rem) >= trial)
                begin
                    q.rem = N_W'(RES_W'(p.rem) - trial);
                    q.res = (p.res >> 1) + bitv;
                end
                else
                begin
                    q.res = p.res >> 1;
                end
            end
            else if (s == ST_DIVI)
            begin
                r    = p.res[R_W-1:0];
                q.dv = {r, 1'b0};
                q.dc = N_W'({p.ma, 30'b0}) + N_W'(r);
                q.ds = N_W'({p.mb, 30'b0}) + N_W'(r);
                q.qc = '0;
                q.qs = '0;
            end
            else if (s >= ST_DIV0 && s < ST_MUL)
            begin
                t_i = Q_W - 1 - (s - ST_DIV0);
                sh  = RES_W'(p.dv) << t_i;
                if (RES_W'(p.dc) >= sh)
                begin
                    q.dc       = N_W'(RES_W'(p.dc) - sh);
                    q.qc[t_i]  = 1'b1;
                end
                if (RES_W'(p.ds) >= sh)
                begin
                    q.ds       = N_W'(RES_W'(p.ds) - sh);
                    q.qs[t_i]  = 1'b1;
                end
            end
            else if (s == ST_MUL)
            begin
                cs = p.sa ? -$signed({1'b0, p.qc}) : $signed({1'b0, p.qc});
                sn = p.sb ? -$signed({1'b0, p.qs}) : $signed({1'b0, p.qs});
                for (int pp = 0; pp < MAX_PAIRS; pp++)
                begin
                    xi = xs_reg[3*pp +: 3];
                    yi = ys_reg[3*pp +: 3];
                    cx = p.v[xi];
                    cy = p.v[yi];
                    q.prod[pp][0] = PROD_W'(PROD_W'(cx) * PROD_W'(sn));
                    q.prod[pp][1] = PROD_W'(PROD_W'(cy) * PROD_W'(cs));
                    q.prod[pp][2] = PROD_W'(PROD_W'(cx) * PROD_W'(cs));
                    q.prod[pp][3] = PROD_W'(PROD_W'(cy) * PROD_W'(sn));
                end
            end
            else if (s == ST_RND)
            begin
                for (int pp = 0; pp < MAX_PAIRS; pp++)
                begin
                    for (int h = 0; h < 2; h++)
                    begin
                        if (h == 0)
                            t = 64'($signed(p.prod[pp][0])) - 64'($signed(p.prod[pp][1]));
                        else
                            t = 64'($signed(p.prod[pp][2])) + 64'($signed(p.prod[pp][3]));
                        tr = (t + (64'sd1 <<< (CS_BITS - 1))) >>> CS_BITS;
                        if (tr > 64'sd2147483647)
                            q.rot[pp][h] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
                        else if (tr < -64'sd2147483648)
                            q.rot[pp][h] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
                        else
                            q.rot[pp][h] = tr[COORD_WIDTH-1:0];
                    end
                end
            end
            else if (s == ST_PLACE)
            begin
                q.o = '0;
                if (np == 3'd0)
                begin
                    for (int i = 0; i < NOUT; i++)
                        if (4'(i) < nout)
                            q.o[i] = p.v[i];
                end
                else
                begin
                    for (int i = 0; i < MAX_DIMS; i++)
                    begin
                        pl = place_fn(3'(i));
                        if (pl[3])
                            q.o[pl[2:0]] = p.v[i];
                    end
                    if (!p.flag)
                    begin
                        for (int pp = 0; pp < MAX_PAIRS; pp++)
                        begin
                            if (3'(pp) < np)
                            begin
                                pl = place_fn(xs_reg[3*pp +: 3]);
                                if (pl[3])
                                    q.o[pl[2:0]] = p.rot[pp][0];
                                pl = place_fn(ys_reg[3*pp +: 3]);
                                if (pl[3])
                                    q.o[pl[2:0]] = p.rot[pp][1];
                            end
                        end
                    end
                end
            end
            stage_fn = q;
        end
    endfunction

    assign adv       = !vld_reg[N_STAGES-1] || rot.ready;
    assign evt.ready = adv;

    always_comb
    begin
        pipe_next[0]   = pipe_reg[0];
        pipe_next[0].v = {evt.coord7, evt.coord6, evt.coord5, evt.coord4,
                          evt.coord3, evt.coord2, evt.coord1, evt.coord0};
        for (int s = 0; s < N_STAGES - 1; s++)
            pipe_next[s+1] = stage_fn(s, pipe_reg[s]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < N_STAGES; s++)
                pipe_reg[s] <= pipe_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[N_STAGES-2:0], evt.valid};
    end

    assign rot.valid    = vld_reg[N_STAGES-1];
    assign rot.out0     = pipe_reg[N_STAGES-1].o[0];
    assign rot.out1     = pipe_reg[N_STAGES-1].o[1];
    assign rot.out2     = pipe_reg[N_STAGES-1].o[2];
    assign rot.out3     = pipe_reg[N_STAGES-1].o[3];
    assign rot.out4     = pipe_reg[N_STAGES-1].o[4];
    assign rot.out5     = pipe_reg[N_STAGES-1].o[5];
    assign rot.out6     = pipe_reg[N_STAGES-1].o[6];
    assign rot.ref_zero = pipe_reg[N_STAGES-1].flag;

endmodule

/* src/avr_checker.sv */
module avr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out0,
    input logic        ref_zero
);
    // output word held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out0) && $stable(ref_zero))
        else $error("output word changed while stalled");

    // stall reaches the input side
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_ready_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked with output free");

endmodule

bind azimuthal_vector_rotation avr_checker u_avr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (evt.ready),
    .out_valid (rot.valid),
    .out_ready (rot.ready),
    .out0      (rot.out0),
    .ref_zero  (rot.ref_zero)
);
